// ===== rtl/cpra_pkg.sv =====
// ============================================================================
// cpra_pkg: shared types, constants and helpers of the page run allocator
// bitmap word layout, status codes and bit search functions
// ============================================================================
`default_nettype none

package cpra_pkg;

    localparam int WORD_BITS         = 64;
    localparam int WORD_LSB          = 6;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int TABLE_LSB         = 10;
    localparam int WORDS_PER_TABLE   = ENTRIES_PER_TABLE / WORD_BITS;
    localparam int TOP_TABLE_LIMIT   = 1022;
    localparam int ADDR_BITS         = 32;
    localparam int PAGE_OFS_BITS     = 12;
    localparam int PAGE_BITS         = ADDR_BITS - PAGE_OFS_BITS;
    localparam int COUNT_BITS        = 15;
    localparam int POS_BITS          = WORD_LSB + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_MISALIGNED = 2'd2,
        ST_OUTSIDE    = 2'd3
    } t_status;

    // one clear stretch followed by one set stretch, starting at a bit position
    typedef struct packed {
        logic [POS_BITS-1:0] len;       // clear bits from the start position
        logic                set_hit;   // a set bit ends the clear stretch
        logic                clr_hit;   // a clear bit follows that set stretch
        logic [WORD_LSB-1:0] next_pos;  // position of that clear bit
    } t_seg;

    // index of the lowest set bit, WORD_BITS if none
    function automatic logic [POS_BITS-1:0] lowest_set(input t_word v);
        logic [POS_BITS-1:0] idx;
        idx = POS_BITS'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = POS_BITS'(i);
            end
        end
        return idx;
    endfunction

    // ones from bit lo up to bit hi
    function automatic t_word range_mask(input logic [WORD_LSB-1:0] lo,
                                         input logic [WORD_LSB-1:0] hi);
        t_word ones;
        ones = '1;
        return (ones << lo) & (ones >> (WORD_LSB'(WORD_BITS - 1) - hi));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/contiguous_page_run_allocator_core.sv =====
// ============================================================================
// contiguous_page_run_allocator_core: first-fit contiguous page run allocator
// present-bit bitmap of a growing kernel window, kept in one block ram
// ============================================================================
// A transaction is taken when start is high and busy is low; each transaction
// gives exactly one result, shown on o_status / o_start_address for one cycle
// while o_valid is high. The receiver cannot stall, so results are never held.
// After reset the bitmap ram is cleared one 64-bit word a cycle, which keeps
// busy high until 16 * min(MAX_TABLES, 1023 - BASE_TABLE) words are clear.
// An allocate scans the bitmap from the start of the window, one ram word per
// cycle, staying on a word for each further clear stretch that begins after
// a set bit inside it. S_FOUND then starts the update, and S_MARK rewrites
// each word the run covers in turn. A free goes straight to S_MARK and
// rewrites each word it covers. Zero-count allocates, misaligned frees,
// out-of-window frees and zero-count frees answer from idle without a bitmap
// access.
// Window growth is resolved from the found run end, so a search never repeats.
// ============================================================================
`default_nettype none

module contiguous_page_run_allocator_core #(
    parameter int MAX_TABLES = 16,
    parameter int BASE_TABLE = 768
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_operation,
    input  wire logic [cpra_pkg::COUNT_BITS-1:0]  i_page_count,
    input  wire logic [cpra_pkg::ADDR_BITS-1:0]   i_address,
    output logic                                  o_valid,
    output cpra_pkg::t_status                     o_status,
    output logic      [cpra_pkg::ADDR_BITS-1:0]   o_start_address
);

    import cpra_pkg::*;

    // largest window: table bound, and never past the top table limit
    localparam int TOP_FIT   = TOP_TABLE_LIMIT + 1 - BASE_TABLE;
    localparam int TMAX      = (MAX_TABLES < TOP_FIT) ? MAX_TABLES : TOP_FIT;
    localparam int MAP_WORDS = TMAX * WORDS_PER_TABLE;
    localparam int WW        = $clog2(MAP_WORDS);
    localparam int PW        = WW + WORD_LSB;
    localparam int AW        = $clog2(TMAX + 1);
    localparam int LW        = PAGE_BITS + 1;

    localparam logic [WW-1:0]        LAST_WORD = WW'(MAP_WORDS - 1);
    localparam logic [PAGE_BITS-1:0] BASE_PAGE = PAGE_BITS'(BASE_TABLE * ENTRIES_PER_TABLE);
    localparam logic [TABLE_LSB-1:0] BASE_TBL  = TABLE_LSB'(BASE_TABLE);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FOUND,
        S_MARK
    } t_state;

    t_state                r_state, n_state;
    logic [WW-1:0]         r_clr_idx, n_clr_idx;
    logic [AW-1:0]         r_active, n_active;
    logic [WW-1:0]         r_widx, n_widx;
    logic [WORD_LSB-1:0]   r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_run, n_run;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [PW-1:0]         r_begin, n_begin;
    logic [PW-1:0]         r_first, n_first;
    logic [PW-1:0]         r_last, n_last;
    logic                  r_fresh, n_fresh;
    logic                  r_clr, n_clr;
    t_word                 r_word, n_word;
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [ADDR_BITS-1:0]  r_start, n_start;

    // ram ports
    logic          rd_en;
    logic [WW-1:0] rd_addr;
    t_word         rd_data;
    logic          wr_en;
    logic [WW-1:0] wr_addr;
    t_word         wr_data;

    // scan datapath
    t_word                 word_cur;
    t_seg                  seg;
    logic [COUNT_BITS:0]   run_total;
    logic                  run_hit;
    logic [PW-1:0]         here_page;

    // free checks
    logic                  accept;
    logic [PAGE_BITS-1:0]  in_page;
    logic [PAGE_BITS-1:0]  rel_page;
    logic [LW-1:0]         win_limit;
    logic                  misaligned;
    logic                  outside;

    // update datapath
    logic [WW-1:0]         first_word;
    logic [WW-1:0]         last_word;
    logic [WORD_LSB-1:0]   mask_lo;
    logic [WORD_LSB-1:0]   mask_hi;
    t_word                 upd_mask;
    logic [AW-1:0]         need_tables;
    logic [TABLE_LSB-1:0]  run_table;

    cpra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // word just read from ram, or the word still being walked through
    assign word_cur = r_fresh ? rd_data : r_word;

    cpra_seg u_seg (
        .i_word (word_cur),
        .i_pos  (r_pos),
        .o_seg  (seg)
    );

    assign run_total = {1'b0, r_run} + (COUNT_BITS + 1)'(seg.len);
    assign run_hit   = run_total >= {1'b0, r_cnt};
    assign here_page = {r_widx, r_pos};

    assign accept     = start & ~busy;
    assign in_page    = i_address[ADDR_BITS-1:PAGE_OFS_BITS];
    assign rel_page   = in_page - BASE_PAGE;
    assign win_limit  = LW'(r_active) << TABLE_LSB;
    assign misaligned = |i_address[PAGE_OFS_BITS-1:0];
    assign outside    = (in_page < BASE_PAGE) ||
                        ({1'b0, rel_page} >= win_limit) ||
                        (LW'(i_page_count) > (win_limit - {1'b0, rel_page}));

    assign first_word  = r_first[PW-1:WORD_LSB];
    assign last_word   = r_last[PW-1:WORD_LSB];
    assign mask_lo     = (r_widx == first_word) ? r_first[WORD_LSB-1:0] : '0;
    assign mask_hi     = (r_widx == last_word) ? r_last[WORD_LSB-1:0] : '1;
    assign upd_mask    = range_mask(mask_lo, mask_hi);
    assign need_tables = AW'(r_last >> TABLE_LSB) + AW'(1);
    assign run_table   = BASE_TBL + TABLE_LSB'(r_first >> TABLE_LSB);

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_active  = r_active;
        n_widx    = r_widx;
        n_pos     = r_pos;
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_begin   = r_begin;
        n_first   = r_first;
        n_last    = r_last;
        n_fresh   = r_fresh;
        n_clr     = r_clr;
        n_word    = r_word;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_start   = r_start;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = r_widx;
        wr_data   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // power-up sweep: every bitmap word to zero
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                if (r_clr_idx == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + WW'(1);
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_cnt = i_page_count;
                    if (i_operation == OP_ALLOC) begin
                        if (i_page_count == '0) begin
                            // nothing ever matches: window grows to its bound
                            n_active = AW'(TMAX);
                            n_valid  = 1'b1;
                            n_status = ST_NO_SPACE;
                            n_start  = '0;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_widx  = '0;
                            n_pos   = '0;
                            n_run   = '0;
                            n_fresh = 1'b1;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_start = '0;
                        if (misaligned) begin
                            n_valid  = 1'b1;
                            n_status = ST_MISALIGNED;
                        end else if (outside) begin
                            n_valid  = 1'b1;
                            n_status = ST_OUTSIDE;
                        end else if (i_page_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                        end else begin
                            n_first = rel_page[PW-1:0];
                            n_last  = PW'(rel_page + PAGE_BITS'(i_page_count) - PAGE_BITS'(1));
                            n_clr   = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = rel_page[PW-1:WORD_LSB];
                            n_widx  = rel_page[PW-1:WORD_LSB];
                            n_state = S_MARK;
                        end
                    end
                end
            end

            S_SCAN: begin
                n_word  = word_cur;
                n_fresh = 1'b0;
                if (run_hit) begin
                    // run complete inside this clear stretch
                    n_first = (r_run == '0) ? here_page : r_begin;
                    n_state = S_FOUND;
                end else begin
                    if (r_run == '0) begin
                        n_begin = here_page;
                    end
                    if (!seg.set_hit) begin
                        // clear to the end of the word, run carries on
                        n_run = run_total[COUNT_BITS-1:0];
                    end else begin
                        n_run = '0;
                    end
                    if (seg.set_hit && seg.clr_hit) begin
                        n_pos = seg.next_pos;
                    end else if (r_widx == LAST_WORD) begin
                        // whole window bound searched
                        n_active = AW'(TMAX);
                        n_valid  = 1'b1;
                        n_status = ST_NO_SPACE;
                        n_start  = '0;
                        n_state  = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_widx + WW'(1);
                        n_widx  = r_widx + WW'(1);
                        n_pos   = '0;
                        n_fresh = 1'b1;
                    end
                end
            end

            S_FOUND: begin
                n_last  = r_first + PW'(r_cnt) - PW'(1);
                n_clr   = 1'b0;
                rd_en   = 1'b1;
                rd_addr = first_word;
                n_widx  = first_word;
                n_state = S_MARK;
            end

            S_MARK: begin
                // read-modify-write, next word read while this one is written
                wr_en   = 1'b1;
                wr_addr = r_widx;
                wr_data = r_clr ? (rd_data & ~upd_mask) : (rd_data | upd_mask);
                if (r_widx == last_word) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    if (r_clr) begin
                        n_start = '0;
                    end else begin
                        n_start = {run_table, r_first[TABLE_LSB-1:0], PAGE_OFS_BITS'(0)};
                        if (need_tables > r_active) begin
                            n_active = need_tables;
                        end
                    end
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_widx + WW'(1);
                    n_widx  = r_widx + WW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_active  <= AW'(1);
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_active  <= n_active;
            r_valid   <= n_valid;
        end
        r_widx   <= n_widx;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_cnt    <= n_cnt;
        r_begin  <= n_begin;
        r_first  <= n_first;
        r_last   <= n_last;
        r_fresh  <= n_fresh;
        r_clr    <= n_clr;
        r_word   <= n_word;
        r_status <= n_status;
        r_start  <= n_start;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_start_address = r_start;

`ifndef SYNTHESIS
    // the power-up sweep keeps transactions out
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy)
        else $error("transaction window open during bitmap clear");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_start_address == '0))
        else $error("start address set on failed transaction");

    // window size stays within its bound
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >= AW'(1)) && (r_active <= AW'(TMAX)))
        else $error("active table count out of range");

    // bitmap written only by the sweep or an update pass
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_CLEAR) || (r_state == S_MARK)))
        else $error("bitmap write outside clear or update");

    // every transaction either answers at once or keeps the block busy
    a_accept_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_valid || busy))
        else $error("transaction dropped");
`endif

endmodule

`default_nettype wire

// ===== rtl/cpra_ram.sv =====
// ============================================================================
// cpra_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ============================================================================
`default_nettype none

module cpra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cpra_seg.sv =====
// ============================================================================
// cpra_seg: run segment finder for one bitmap word
// measures the clear stretch at a position and finds the next clear bit
// ============================================================================
`default_nettype none

module cpra_seg (
    input  wire cpra_pkg::t_word              i_word,
    input  wire logic [cpra_pkg::WORD_LSB-1:0] i_pos,
    output cpra_pkg::t_seg                    o_seg
);

    import cpra_pkg::*;

    t_word               ones;
    t_word               set_vec;
    t_word               clr_vec;
    logic [POS_BITS-1:0] set_idx;
    logic [POS_BITS-1:0] clr_idx;

    assign ones    = '1;
    assign set_vec = i_word & (ones << i_pos);
    assign set_idx = lowest_set(set_vec);
    // no set bit left means no clear bit after it either
    assign clr_vec = set_idx[WORD_LSB] ? '0 : (~i_word & (ones << set_idx[WORD_LSB-1:0]));
    assign clr_idx = lowest_set(clr_vec);

    always_comb begin
        o_seg.len      = set_idx - {1'b0, i_pos};
        o_seg.set_hit  = ~set_idx[WORD_LSB];
        o_seg.clr_hit  = ~clr_idx[WORD_LSB];
        o_seg.next_pos = clr_idx[WORD_LSB-1:0];
    end

endmodule

`default_nettype wire
